@@ hw/rtl/bshs_pkg.sv @@
// bshs_pkg: shared types and constants of the backup stream header stripper
// used by bshs_csr, bshs_frame and backup_stream_header_stripper
// no dependencies
package bshs_pkg;

   // record framing
   localparam int unsigned HeaderBytes = 20;
   localparam int unsigned HdrLeftWidth = 5;
   localparam int unsigned BodyWidth = 64;
   localparam logic [31:0] PassStreamId = 32'd1;

   // configuration port: one 32-bit register, index taken from paddr[2]
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;
   localparam logic CsrIdxStripEnable = 1'b0;

   // one transaction handed to the framing logic
   typedef struct packed {
      logic       fire;
      logic       strip;
      logic [7:0] data;
   } bshs_step_type;

   // what the framing logic makes of it
   typedef struct packed {
      logic       emit;
      logic [7:0] data;
   } bshs_result_type;

endpackage

@@ hw/rtl/backup_stream_header_stripper.sv @@
// Backup stream header stripper. Takes one byte per transaction on req_ and
// gives at most one byte per transaction on rsp_. With strip enable set, the
// 20-byte record headers are consumed and only body bytes of stream id 1 are
// passed; otherwise every byte passes. A byte goes through an input register
// and the framing logic into the output register, and a new byte is taken
// every cycle while the output side is not stalled.
// depends on bshs_pkg, bshs_csr, bshs_frame
module backup_stream_header_stripper
   import bshs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // input channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_out_byte,
   // configuration port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   logic            strip_enable;
   logic            in_vld_ff;
   logic            in_vld_in;
   logic [7:0]      in_byte_ff;
   logic            out_vld_ff;
   logic            out_vld_in;
   logic [7:0]      out_byte_ff;
   logic            advance;
   logic            in_load;
   bshs_step_type   step;
   bshs_result_type res;

   bshs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .strip_enable (strip_enable)
   );

   // handshake: the input register moves on whenever the output slot frees
   assign advance   = !out_vld_ff || !rsp_stall;
   assign req_stall = in_vld_ff && !advance;
   assign in_load   = req_valid && !req_stall;
   assign in_vld_in = req_stall ? 1'b1 : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_byte_ff <= req_data_byte;
      end
   end

   // framing step on the registered byte
   assign step.fire  = in_vld_ff && advance;
   assign step.strip = strip_enable;
   assign step.data  = in_byte_ff;

   bshs_frame u_frame (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .res   (res)
   );

   // output register
   assign out_vld_in = advance ? res.emit : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.emit) begin
         out_byte_ff <= res.data;
      end
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_out_byte = out_byte_ff;

   // input side only waits behind a held byte
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff)
      else $error("input stalled with empty input register");

   // pass-through always produces a result
   a_bypass_emits: assert property (@(posedge clock) disable iff (reset)
      step.fire && !strip_enable |=> out_vld_ff && out_byte_ff == $past(in_byte_ff))
      else $error("pass-through byte lost");

endmodule

@@ hw/rtl/bshs_csr.sv @@
// bshs_csr: apb-style configuration register (strip enable)
// depends on bshs_pkg
module bshs_csr
   import bshs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready,
   output logic                    strip_enable
);

   logic strip_enable_ff;
   logic strip_enable_in;
   logic wr_access;
   logic reg_index;

   assign pready    = 1'b1;
   assign wr_access = psel && penable && pwrite;
   assign reg_index = paddr[2];

   // register write decode
   always_comb begin
      strip_enable_in = strip_enable_ff;
      if (wr_access) begin
         unique case (reg_index)
            CsrIdxStripEnable: strip_enable_in = pwdata[0];
            default:           strip_enable_in = strip_enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_enable_ff <= 1'b0;
      end else begin
         strip_enable_ff <= strip_enable_in;
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      unique case (reg_index)
         CsrIdxStripEnable: prdata = {{(CsrDataWidth-1){1'b0}}, strip_enable_ff};
         default:           prdata = '0;
      endcase
   end

   assign strip_enable = strip_enable_ff;

endmodule

@@ hw/rtl/bshs_frame.sv @@
// bshs_frame: record framing state, header capture and body pass/drop decision
// depends on bshs_pkg
module bshs_frame
   import bshs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  bshs_step_type   step,
   output bshs_result_type res
);

   localparam logic [HdrLeftWidth-1:0] HdrFull = HdrLeftWidth'(HeaderBytes);

   // header bytes 0 .. HeaderBytes-2 in arrival order; the last one is the live byte
   logic [7:0]              hdr_ff [HeaderBytes-1];
   logic [7:0]              hdr_in [HeaderBytes-1];
   logic [HdrLeftWidth-1:0] hdr_left_ff;
   logic [HdrLeftWidth-1:0] hdr_left_in;
   logic [BodyWidth-1:0]    body_left_ff;
   logic [BodyWidth-1:0]    body_left_in;
   logic                    body_pass_ff;
   logic                    body_pass_in;

   logic [HdrLeftWidth-1:0] hdr_left_eff;
   logic [HdrLeftWidth-1:0] hdr_left_dec;
   logic [BodyWidth-1:0]    body_left_dec;
   logic                    in_header;
   logic [7:0]              hdr_full [HeaderBytes];
   logic [31:0]             stream_id;
   logic [63:0]             data_size;
   logic [31:0]             name_size;
   logic [BodyWidth:0]      body_sum;
   logic [BodyWidth-1:0]    body_sat;

   // nothing outstanding restarts header collection
   assign hdr_left_eff  = (hdr_left_ff == '0 && body_left_ff == '0) ? HdrFull : hdr_left_ff;
   assign in_header     = (hdr_left_eff != '0);
   assign hdr_left_dec  = hdr_left_eff - HdrLeftWidth'(1);
   assign body_left_dec = body_left_ff - BodyWidth'(1);

   // full header view with the live byte as the last one
   always_comb begin
      for (int i = 0; i < HeaderBytes - 1; i++) begin
         hdr_full[i] = hdr_ff[i];
      end
      hdr_full[HeaderBytes-1] = step.data;
   end

   // little-endian header fields
   assign stream_id = {hdr_full[3], hdr_full[2], hdr_full[1], hdr_full[0]};
   assign data_size = {hdr_full[15], hdr_full[14], hdr_full[13], hdr_full[12],
                       hdr_full[11], hdr_full[10], hdr_full[9], hdr_full[8]};
   assign name_size = {hdr_full[19], hdr_full[18], hdr_full[17], hdr_full[16]};

   // body length with saturation
   assign body_sum = {1'b0, data_size} + {33'b0, name_size};
   assign body_sat = body_sum[BodyWidth] ? '1 : body_sum[BodyWidth-1:0];

   // next state
   always_comb begin
      hdr_in       = hdr_ff;
      hdr_left_in  = hdr_left_ff;
      body_left_in = body_left_ff;
      body_pass_in = body_pass_ff;
      if (step.fire && step.strip) begin
         if (in_header) begin
            for (int i = 0; i < HeaderBytes - 2; i++) begin
               hdr_in[i] = hdr_ff[i+1];
            end
            hdr_in[HeaderBytes-2] = step.data;
            hdr_left_in = hdr_left_dec;
            if (hdr_left_dec == '0) begin
               body_left_in = body_sat;
               body_pass_in = (stream_id == PassStreamId);
               hdr_left_in  = (body_sat == '0) ? HdrFull : '0;
            end
         end else begin
            body_left_in = body_left_dec;
            if (body_left_dec == '0) begin
               hdr_left_in = HdrFull;
            end
         end
      end
   end

   // header bytes carry no reset
   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_left_ff  <= HdrFull;
         body_left_ff <= '0;
         body_pass_ff <= 1'b0;
      end else begin
         hdr_left_ff  <= hdr_left_in;
         body_left_ff <= body_left_in;
         body_pass_ff <= body_pass_in;
      end
   end

   // result of this transaction
   assign res.emit = step.fire && (!step.strip || (!in_header && body_pass_ff));
   assign res.data = step.data;

   // header count stays within a record header
   a_hdr_left_range: assert property (@(posedge clock) disable iff (reset)
      hdr_left_ff <= HdrFull)
      else $error("header count out of range");

   // body and header are never outstanding at once
   a_body_excl_hdr: assert property (@(posedge clock) disable iff (reset)
      body_left_ff != '0 |-> hdr_left_ff == '0)
      else $error("body outstanding during header collection");

   // pass-through leaves framing untouched
   a_bypass_hold: assert property (@(posedge clock) disable iff (reset)
      step.fire && !step.strip |=> $stable(hdr_left_ff) && $stable(body_left_ff))
      else $error("framing changed while stripping off");

endmodule

@@ tb/sv/backup_stream_header_stripper_tb.sv @@
// backup_stream_header_stripper_tb: self-checking testbench of the backup stream header stripper
// drives byte transactions with random gaps and stalls, predicts the stripped stream and checks it
// depends on bshs_pkg and backup_stream_header_stripper
module backup_stream_header_stripper_tb;
   import bshs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PipeDepth = 2;
   localparam int CycleLimit = 1000000;
   localparam int RandomBytes = 1500;
   localparam logic [CsrAddrWidth-1:0] AddrStrip = {CsrIdxStripEnable, 2'b00};
   localparam logic [CsrAddrWidth-1:0] AddrSpare = {~CsrIdxStripEnable, 2'b00};

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [7:0]              req_data_byte = 8'h00;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [7:0]              rsp_out_byte;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] paddr = '0;
   logic [CsrDataWidth-1:0] pwdata = '0;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   // predicted framing state
   logic                    model_strip = 1'b0;
   logic [7:0]              hdr_bytes [HeaderBytes];
   logic [HdrLeftWidth-1:0] hdr_left = HdrLeftWidth'(HeaderBytes);
   logic [BodyWidth-1:0]    body_left = '0;
   logic                    body_passes = 1'b0;

   logic [7:0] expected_out_bytes [$];
   int         error_count = 0;
   int         cycle_count = 0;
   int         bytes_sent = 0;
   bit         sender_burst = 1'b0;
   int         stall_hold = 0;
   logic       stall_level = 1'b0;
   int         stall_roll;

   backup_stream_header_stripper dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // one byte through the deframer; returns 1 when a byte comes out
   function automatic bit deframe_byte(input logic [7:0] b, output logic [7:0] ob);
      logic [63:0] size_field;
      logic [31:0] name_field;
      logic [31:0] id_field;
      logic [64:0] body_sum;
      ob = b;
      if (!model_strip) return 1'b1;
      if (hdr_left == 0 && body_left == 0) hdr_left = HdrLeftWidth'(HeaderBytes);
      if (hdr_left != 0) begin
         if (hdr_left > HeaderBytes) hdr_left = HdrLeftWidth'(HeaderBytes);
         hdr_bytes[HeaderBytes - hdr_left] = b;
         hdr_left = hdr_left - 1'b1;
         if (hdr_left == 0) begin
            for (int i = 0; i < 4; i++) begin
               id_field[8*i +: 8] = hdr_bytes[i];
               name_field[8*i +: 8] = hdr_bytes[16+i];
            end
            for (int i = 0; i < 8; i++) size_field[8*i +: 8] = hdr_bytes[8+i];
            body_sum = {1'b0, size_field} + {33'b0, name_field};
            body_left = body_sum[64] ? '1 : body_sum[63:0];
            body_passes = (id_field == PassStreamId);
            if (body_left == 0) hdr_left = HdrLeftWidth'(HeaderBytes);
         end
         return 1'b0;
      end
      body_left = body_left - 1'b1;
      if (body_left == 0) hdr_left = HdrLeftWidth'(HeaderBytes);
      return body_passes;
   endfunction

   // result side: random stall pattern and check against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_out_bytes.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %02h",
                     $time, rsp_out_byte);
            error_count <= error_count + 1;
         end else if (expected_out_bytes[0] !== rsp_out_byte) begin
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, expected_out_bytes[0], rsp_out_byte);
            error_count <= error_count + 1;
            void'(expected_out_bytes.pop_front());
         end else begin
            void'(expected_out_bytes.pop_front());
         end
      end
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 4) begin
            stall_level <= 1'b1;
            stall_hold <= $urandom_range(15, 50);
         end else if (stall_roll < 30) begin
            stall_level <= 1'b1;
            stall_hold <= $urandom_range(0, 2);
         end else if (stall_roll < 40) begin
            stall_level <= 1'b0;
            stall_hold <= $urandom_range(40, 150);
         end else begin
            stall_level <= 1'b0;
            stall_hold <= $urandom_range(0, 5);
         end
      end
   end
   always @(posedge clock) rsp_stall <= stall_level;

   // sender gap length: mostly none or short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (sender_burst || roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // one byte transaction; returns at the edge where it is taken
   task automatic send_byte(input logic [7:0] b);
      int         gap;
      logic [7:0] ob;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (deframe_byte(b, ob)) expected_out_bytes.push_back(ob);
      bytes_sent++;
   endtask

   // stop sending and wait for every outstanding byte
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_out_bytes.size() != 0) @(posedge clock);
      repeat (PipeDepth + 2) @(posedge clock);
   endtask

   // a setup and an access phase, then an idle phase on the bus
   task automatic apb_cycle(input bit wr, input logic [CsrAddrWidth-1:0] addr,
                            input logic [CsrDataWidth-1:0] wdata,
                            output logic [CsrDataWidth-1:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic verify_strip_reg();
      logic [CsrDataWidth-1:0] rdata;
      apb_cycle(1'b0, AddrStrip, '0, rdata);
      if (rdata !== CsrDataWidth'(model_strip)) begin
         $display("%0t: strip_enable readback mismatch, expected %08h, actual %08h",
                  $time, CsrDataWidth'(model_strip), rdata);
         error_count++;
      end
   endtask

   task automatic csr_write(input logic [CsrAddrWidth-1:0] addr,
                            input logic [CsrDataWidth-1:0] data);
      logic [CsrDataWidth-1:0] unused;
      wait_idle();
      apb_cycle(1'b1, addr, data, unused);
      if (addr == AddrStrip) model_strip = data[0];
      verify_strip_reg();
   endtask

   // little-endian record header with random attributes
   function automatic logic [159:0] make_header(input logic [31:0] id, input logic [63:0] size,
                                                input logic [31:0] name);
      return {name, size, 32'($urandom), id};
   endfunction

   task automatic send_record(input logic [31:0] id, input logic [63:0] size,
                              input logic [31:0] name, input int body_bytes);
      logic [159:0] hdr;
      hdr = make_header(id, size, name);
      for (int i = 0; i < HeaderBytes; i++) send_byte(hdr[8*i +: 8]);
      repeat (body_bytes) send_byte(8'($urandom));
   endtask

   // reset value of the register and plain pass-through
   task automatic test_passthrough();
      verify_strip_reg();
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'haa);
      send_byte(8'h55);
      send_byte(8'h01);
      send_byte(8'h80);
   endtask

   // writes to an unmapped register change nothing
   task automatic test_spare_register();
      csr_write(AddrSpare, '1);
      send_byte(8'h7f);
      send_byte(8'hfe);
   endtask

   // stripped records: passing, dropped, zero length and near-miss ids
   task automatic test_strip_records();
      csr_write(AddrStrip, 32'd1);
      send_record(32'd1, 64'd2, 32'd1, 3);
      send_record(32'd1, 64'd0, 32'd0, 0);
      send_record(32'd1, 64'd0, 32'd1, 1);
      send_record(32'hffff_ffff, 64'd1, 32'd0, 1);
      send_record(32'h0000_0101, 64'd1, 32'd1, 2);
      send_record(32'h0100_0001, 64'd1, 32'd0, 1);
      send_record(32'd0, 64'd1, 32'd0, 1);
   endtask

   // toggling strip mode mid-header keeps the framing position
   task automatic test_mode_switch();
      logic [159:0] hdr;
      hdr = make_header(32'd1, 64'd2, 32'd1);
      for (int i = 0; i < 9; i++) send_byte(hdr[8*i +: 8]);
      csr_write(AddrStrip, 32'd0);
      repeat (4) send_byte(8'($urandom));
      csr_write(AddrStrip, 32'd1);
      for (int i = 9; i < HeaderBytes; i++) send_byte(hdr[8*i +: 8]);
      repeat (3) send_byte(8'($urandom));
   endtask

   // random record streams mixed with pass-through noise
   task automatic test_random_stream();
      int          roll;
      int          total;
      logic [31:0] id;
      logic [63:0] size;
      logic [31:0] name;
      while (bytes_sent < RandomBytes) begin
         sender_burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) != 0) begin
            csr_write(AddrStrip, 32'd1);
            repeat ($urandom_range(3, 15)) begin
               roll = $urandom_range(0, 99);
               if (roll < 60) id = 32'd1;
               else if (roll < 75) id = 32'd1 ^ (32'd1 << $urandom_range(0, 31));
               else if (roll < 85) id = 32'd0;
               else id = $urandom;
               roll = $urandom_range(0, 99);
               if (roll < 10) total = 0;
               else if (roll < 85) total = $urandom_range(1, 12);
               else total = $urandom_range(13, 64);
               size = 64'($urandom_range(0, total));
               name = 32'(total) - 32'(size);
               send_record(id, size, name, total);
            end
         end else begin
            csr_write(AddrStrip, 32'({$urandom} & 32'hffff_fffe));
            repeat ($urandom_range(10, 60)) send_byte(8'($urandom));
         end
         // hold off until the output side has caught up
         if ($urandom_range(0, 4) == 0) wait_idle();
      end
      sender_burst = 1'b0;
   endtask

   // overflowing body length saturates; framing never leaves this body
   task automatic test_body_saturation();
      csr_write(AddrStrip, 32'd1);
      send_record(32'd1, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 30);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_passthrough();
      test_spare_register();
      test_strip_records();
      test_mode_switch();
      test_random_stream();
      test_body_saturation();
      wait_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_out_bytes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/bshs_pkg.sv
hw/rtl/bshs_csr.sv
hw/rtl/bshs_frame.sv
hw/rtl/backup_stream_header_stripper.sv
tb/sv/backup_stream_header_stripper_tb.sv
